// File: hdl/dit_pkg.sv
// Package for disjoint_interval_tracker: status codes, mode codes, FSM states.
// No dependencies.
`default_nettype none
package dit_pkg;
  localparam logic [2:0] StAdded   = 3'd0;
  localparam logic [2:0] StCovered = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StEntry   = 3'd3;
  localparam logic [2:0] StEmpty   = 3'd4;
  localparam logic ModeAdd  = 1'b0;
  localparam logic ModeList = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WRITE, S_LIST, S_OUT
  } state_e;
endpackage
`default_nettype wire

// File: hdl/dit_if.sv
// Valid/ready channel interfaces for disjoint_interval_tracker.
// Depends on nothing; widths set by VALUE_BITS.
`default_nettype none
interface dit_in_if #(parameter int unsigned VALUE_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [VALUE_BITS-1:0] new_value;
  modport source (output valid, mode, new_value, input ready);
  modport sink   (input valid, mode, new_value, output ready);
endinterface

interface dit_out_if #(parameter int unsigned VALUE_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] interval_start;
  logic [VALUE_BITS-1:0] interval_end;
  logic [2:0]            status;
  logic                  last;
  modport source (output valid, interval_start, interval_end, status, last, input ready);
  modport sink   (input valid, interval_start, interval_end, status, last, output ready);
endinterface
`default_nettype wire

// File: hdl/disjoint_interval_tracker.sv
// Top level of disjoint_interval_tracker: sorted interval table in one memory.
// Depends on dit_pkg and dit_if.
//
//  channel | dir | payload
//  in_i    | in  | mode, new_value
//  out_o   | out | interval_start, interval_end, status, last
//
// Add: a scan (one read per entry), a decide step, then a read and a write to
// extend an entry (also ahead of a merge), or a read and a write per moved entry plus a
// final step for an insert or a merge, then the result is loaded once the output is free.
// List: per entry a read, then an emit, which waits out any output stall.
// Reset clears the state, the count and the output and read-valid flags; the memory needs no clearing.
// in_i.ready is high only in idle with the output register empty; out_o holds its item
// until taken.
`default_nettype none
module disjoint_interval_tracker #(
  parameter int unsigned MAX_INTERVALS = 32,
  parameter int unsigned VALUE_BITS    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dit_in_if.sink    in_i,
  dit_out_if.source out_o
);
  localparam int unsigned IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [VALUE_BITS-1:0] VMax = '1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] s;
    logic [VALUE_BITS-1:0] e;
  } span_t;

  span_t mem [MAX_INTERVALS];
  span_t rd_q;
  logic          we;
  logic [IW-1:0] wa, ra;
  span_t         wd;
  logic          re;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  dit_pkg::state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [VALUE_BITS-1:0] v_q, v_d;
  logic          cov_q, cov_d, lo_f_q, lo_f_d, hi_f_q, hi_f_d;
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          pos_f_q, pos_f_d;
  logic [VALUE_BITS-1:0] hie_q, hie_d;
  logic          rdv_q;
  // shift: tgt is destination index; dir 1 = up (insert), 0 = down (remove)
  logic [CW-1:0] tgt_q, tgt_d;
  logic          dir_q, dir_d;
  logic          ph_q, ph_d;
  logic          ov_q, ov_d;
  logic [VALUE_BITS-1:0] os_q, os_d, oe_q, oe_d;
  logic [2:0]    ost_q, ost_d;
  logic          ol_q, ol_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= dit_pkg::S_IDLE;
      cnt_q <= '0;
      ov_q  <= 1'b0;
      rdv_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
      rdv_q <= re;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; v_q <= v_d; cov_q <= cov_d; lo_f_q <= lo_f_d; hi_f_q <= hi_f_d;
    lo_q <= lo_d; hi_q <= hi_d; pos_q <= pos_d; pos_f_q <= pos_f_d; hie_q <= hie_d;
    tgt_q <= tgt_d; dir_q <= dir_d; ph_q <= ph_d;
    os_q <= os_d; oe_q <= oe_d; ost_q <= ost_d; ol_q <= ol_d;
  end

  logic out_free;
  assign out_free = !ov_q || out_o.ready;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; idx_d = idx_q; v_d = v_q; cov_d = cov_q;
    lo_f_d = lo_f_q; hi_f_d = hi_f_q; lo_d = lo_q; hi_d = hi_q; pos_d = pos_q;
    pos_f_d = pos_f_q; hie_d = hie_q; tgt_d = tgt_q; dir_d = dir_q; ph_d = ph_q;
    os_d = os_q; oe_d = oe_q; ost_d = ost_q; ol_d = ol_q;
    ov_d = ov_q && !out_o.ready;
    we = 1'b0; wa = '0; wd = '0; re = 1'b0; ra = '0;
    in_i.ready = 1'b0;
    unique case (st_q)
      dit_pkg::S_IDLE: begin
        in_i.ready = !ov_q;
        if (in_i.valid && !ov_q) begin
          idx_d = '0; v_d = in_i.new_value;
          cov_d = 1'b0; lo_f_d = 1'b0; hi_f_d = 1'b0; pos_f_d = 1'b0;
          pos_d = cnt_q;
          if (in_i.mode == dit_pkg::ModeAdd) st_d = dit_pkg::S_SCAN;
          else if (cnt_q == '0) begin
            os_d = '0; oe_d = '0; ost_d = dit_pkg::StEmpty; ol_d = 1'b1; ov_d = 1'b1;
          end else st_d = dit_pkg::S_LIST;
        end
      end
      dit_pkg::S_SCAN: begin
        if (idx_q < cnt_q) begin
          re = 1'b1; ra = idx_q[IW-1:0];
        end
        if (rdv_q) begin
          if (rd_q.s <= v_q && v_q <= rd_q.e) cov_d = 1'b1;
          if (v_q != '0 && rd_q.e == v_q - 1'b1) begin
            lo_f_d = 1'b1; lo_d = IW'(idx_q - 1'b1);
          end
          if (v_q != VMax && rd_q.s == v_q + 1'b1) begin
            hi_f_d = 1'b1; hi_d = IW'(idx_q - 1'b1); hie_d = rd_q.e;
          end
          if (!pos_f_q && !(rd_q.s < v_q)) begin
            pos_f_d = 1'b1; pos_d = idx_q - 1'b1;
          end
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == cnt_q) st_d = dit_pkg::S_DECIDE;
      end
      dit_pkg::S_DECIDE: begin
        ost_d = dit_pkg::StAdded;
        st_d = dit_pkg::S_OUT;
        if (cov_q) ost_d = dit_pkg::StCovered;
        else if (lo_f_q && hi_f_q) begin
          // merged into lo (hi = lo+1); then shift down from hi
          st_d = dit_pkg::S_WRITE; ph_d = 1'b0;
        end else if (hi_f_q) begin
          st_d = dit_pkg::S_WRITE; ph_d = 1'b0;
        end else if (lo_f_q) begin
          st_d = dit_pkg::S_WRITE; ph_d = 1'b0;
        end else if (cnt_q >= CW'(MAX_INTERVALS)) ost_d = dit_pkg::StFull;
        else begin
          dir_d = 1'b1; tgt_d = cnt_q; ph_d = 1'b0; st_d = dit_pkg::S_SHIFT;
        end
      end
      dit_pkg::S_WRITE: begin
        // read-modify-write of one entry
        if (!ph_q) begin
          re = 1'b1; ra = hi_f_q ? (lo_f_q ? lo_q : hi_q) : lo_q; ph_d = 1'b1;
        end else begin
          we = 1'b1; wd = rd_q;
          if (lo_f_q && hi_f_q) begin
            wa = lo_q; wd.e = hie_q;
            dir_d = 1'b0; tgt_d = CW'(hi_q); ph_d = 1'b0;
            st_d = dit_pkg::S_SHIFT;
          end else if (hi_f_q) begin
            wa = hi_q; wd.s = v_q; st_d = dit_pkg::S_OUT;
          end else begin
            wa = lo_q; wd.e = v_q; st_d = dit_pkg::S_OUT;
          end
        end
      end
      dit_pkg::S_SHIFT: begin
        if (dir_q) begin
          if (tgt_q == pos_q) begin
            we = 1'b1; wa = tgt_q[IW-1:0]; wd.s = v_q; wd.e = v_q;
            cnt_d = cnt_q + 1'b1; st_d = dit_pkg::S_OUT;
          end else if (!ph_q) begin
            re = 1'b1; ra = IW'(tgt_q - 1'b1); ph_d = 1'b1;
          end else begin
            we = 1'b1; wa = tgt_q[IW-1:0]; wd = rd_q;
            tgt_d = tgt_q - 1'b1; ph_d = 1'b0;
          end
        end else begin
          if (tgt_q + 1'b1 >= cnt_q) begin
            cnt_d = cnt_q - 1'b1; st_d = dit_pkg::S_OUT;
          end else if (!ph_q) begin
            re = 1'b1; ra = IW'(tgt_q + 1'b1); ph_d = 1'b1;
          end else begin
            we = 1'b1; wa = tgt_q[IW-1:0]; wd = rd_q;
            tgt_d = tgt_q + 1'b1; ph_d = 1'b0;
          end
        end
      end
      dit_pkg::S_OUT: begin
        if (out_free) begin
          os_d = '0; oe_d = '0; ol_d = 1'b1; ov_d = 1'b1; st_d = dit_pkg::S_IDLE;
        end
      end
      dit_pkg::S_LIST: begin
        // ph_q: read issued for idx_q
        if (!ph_q) begin
          re = 1'b1; ra = idx_q[IW-1:0]; ph_d = 1'b1;
        end else if (out_free) begin
          os_d = rd_q.s; oe_d = rd_q.e; ost_d = dit_pkg::StEntry;
          ol_d = (idx_q + 1'b1 == cnt_q); ov_d = 1'b1; ph_d = 1'b0;
          idx_d = idx_q + 1'b1;
          if (idx_q + 1'b1 == cnt_q) st_d = dit_pkg::S_IDLE;
        end
      end
      default: st_d = dit_pkg::S_IDLE;
    endcase
    if (st_q == dit_pkg::S_IDLE && in_i.valid && !ov_q) ph_d = 1'b0;
  end

  assign out_o.valid          = ov_q;
  assign out_o.interval_start = os_q;
  assign out_o.interval_end   = oe_q;
  assign out_o.status         = ost_q;
  assign out_o.last           = ol_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_INTERVALS)) else $error("count overflow");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> st_q == dit_pkg::S_IDLE) else $error("ready outside idle");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |-> $past(st_q) == dit_pkg::S_SHIFT) else $error("count jump");
endmodule
`default_nettype wire
